@@ sv/pvtl_pkg.sv @@
// ----------------------------------------------------------------------------
// pvtl_pkg
// Shared types and constants for the VCO tuning PI loop.
// ----------------------------------------------------------------------------
package pvtl_pkg;

   localparam int DAC_BITS_DEFAULT   = 12;
   localparam int ERROR_BITS_DEFAULT = 32;

   localparam int GAIN_BITS      = 16;
   localparam int STEP_BITS      = 12;
   localparam int ALPHA_BITS     = 9;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Guard bits of the P+I sum over the error width: 17-bit signed gain product,
   // minus the Q8 shift, plus one carry bit.
   localparam int PI_GUARD_BITS = 10;

   localparam logic [GAIN_BITS-1:0]  PROP_GAIN_RESET    = 16'd128;
   localparam logic [GAIN_BITS-1:0]  INTEG_GAIN_RESET   = 16'd16;
   localparam logic [GAIN_BITS-1:0]  DAC_SCALE_RESET    = 16'd1000;
   localparam logic [STEP_BITS-1:0]  STEP_LIMIT_RESET   = 12'd64;
   localparam logic [ALPHA_BITS-1:0] SMOOTH_ALPHA_RESET = 9'd64;
   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE          = 9'd256;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PROP_GAIN    = 3'd0,
      CSR_INTEG_GAIN   = 3'd1,
      CSR_DAC_SCALE    = 3'd2,
      CSR_STEP_LIMIT   = 3'd3,
      CSR_SMOOTH_ALPHA = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_MUL_P,
      OP_ACC_P,
      OP_MUL_I,
      OP_ACC_I,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_LIMIT,
      OP_BLEND
   } dp_op_type;

   typedef struct packed {
      logic      load;   // capture error, update integral
      dp_op_type op;
   } dp_cmd_type;

endpackage

@@ sv/pvtl_ctrl.sv @@
// ----------------------------------------------------------------------------
// pvtl_ctrl
// Sequencer for the PI loop: steps the datapath through one update per item.
// ----------------------------------------------------------------------------
module pvtl_ctrl #(
   parameter int ERROR_BITS = pvtl_pkg::ERROR_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pvtl_pkg::dp_cmd_type cmd
);

   localparam int DivSteps = ERROR_BITS + pvtl_pkg::PI_GUARD_BITS;
   localparam int CntBits  = $clog2(DivSteps);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_P,
      S_ACC_P,
      S_MUL_I,
      S_ACC_I,
      S_DIV_INIT,
      S_DIV,
      S_LIMIT,
      S_BLEND
   } state_type;

   state_type          state_ff, state_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.load     = 1'b0;
      cmd.op       = pvtl_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL_P;
            end
         end
         S_MUL_P: begin
            cmd.op   = pvtl_pkg::OP_MUL_P;
            state_in = S_ACC_P;
         end
         S_ACC_P: begin
            cmd.op   = pvtl_pkg::OP_ACC_P;
            state_in = S_MUL_I;
         end
         S_MUL_I: begin
            cmd.op   = pvtl_pkg::OP_MUL_I;
            state_in = S_ACC_I;
         end
         S_ACC_I: begin
            cmd.op   = pvtl_pkg::OP_ACC_I;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op   = pvtl_pkg::OP_DIV_INIT;
            cnt_in   = CntBits'(DivSteps - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = pvtl_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_LIMIT;
            end
         end
         S_LIMIT: begin
            cmd.op   = pvtl_pkg::OP_LIMIT;
            state_in = S_BLEND;
         end
         S_BLEND: begin
            // hold until the previous result has been transferred
            if (slot_free) begin
               cmd.op       = pvtl_pkg::OP_BLEND;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/pvtl_datapath.sv @@
// ----------------------------------------------------------------------------
// pvtl_datapath
// Config registers, integral, shared gain multiplier, restoring divider,
// rate limit and low-pass blend of the PI loop.
// ----------------------------------------------------------------------------
module pvtl_datapath #(
   parameter int DAC_BITS   = pvtl_pkg::DAC_BITS_DEFAULT,
   parameter int ERROR_BITS = pvtl_pkg::ERROR_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [pvtl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pvtl_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  pvtl_pkg::dp_cmd_type                cmd,
   input  logic signed [ERROR_BITS-1:0]        req_freq_error,
   output logic [DAC_BITS-1:0]                 rsp_dac_code
);

   localparam int GainBits  = pvtl_pkg::GAIN_BITS;
   localparam int StepBits  = pvtl_pkg::STEP_BITS;
   localparam int AlphaBits = pvtl_pkg::ALPHA_BITS;
   localparam int PiBits    = ERROR_BITS + pvtl_pkg::PI_GUARD_BITS;
   localparam int ProdBits  = ERROR_BITS + GainBits + 1;
   localparam int TermBits  = ProdBits - 8;
   localparam int SumBits   = (DAC_BITS > StepBits ? DAC_BITS : StepBits) + 2;
   localparam int BlendBits = DAC_BITS + AlphaBits;

   // configuration
   logic [GainBits-1:0]  prop_gain_ff, integ_gain_ff, dac_scale_ff;
   logic [StepBits-1:0]  step_limit_ff;
   logic [AlphaBits-1:0] smooth_alpha_ff;

   // loop state and working registers
   logic signed [ERROR_BITS-1:0] err_ff, esum_ff, esum_in;
   logic signed [ProdBits-1:0]   prod_ff, prod_in;
   logic signed [PiBits-1:0]     pi_ff;
   logic [PiBits-1:0]            dq_ff, dq_in;
   logic [GainBits-1:0]          rem_ff, rem_in;
   logic                         neg_ff;
   logic [DAC_BITS-1:0]          raw_ff, raw_in;
   logic [DAC_BITS-1:0]          last_output_ff;

   logic signed [ERROR_BITS:0]   esum_wide;
   logic [GainBits-1:0]          mul_a;
   logic signed [ERROR_BITS-1:0] mul_b;
   logic [TermBits-1:0]          term;
   logic [PiBits-1:0]            term_ext;
   logic [PiBits-1:0]            pi_mag;
   logic [GainBits-1:0]          divisor;
   logic [GainBits:0]            rem_shift, rem_diff;
   logic                         quo_bit;
   logic [StepBits-1:0]          delta_mag;
   logic [StepBits:0]            delta;
   logic [SumBits-1:0]           raw_sum;
   logic [AlphaBits-1:0]         alpha, alpha_inv;
   logic [BlendBits-1:0]         blend_sum;

   assign rsp_dac_code = last_output_ff;

   // saturating integral update
   assign esum_wide = {esum_ff[ERROR_BITS-1], esum_ff}
                    + {req_freq_error[ERROR_BITS-1], req_freq_error};
   always_comb begin
      if (esum_wide[ERROR_BITS] != esum_wide[ERROR_BITS-1]) begin
         esum_in = esum_wide[ERROR_BITS] ? {1'b1, {(ERROR_BITS-1){1'b0}}}
                                         : {1'b0, {(ERROR_BITS-1){1'b1}}};
      end else begin
         esum_in = esum_wide[ERROR_BITS-1:0];
      end
   end

   // shared gain multiplier
   assign mul_a   = (cmd.op == pvtl_pkg::OP_MUL_I) ? integ_gain_ff : prop_gain_ff;
   assign mul_b   = (cmd.op == pvtl_pkg::OP_MUL_I) ? esum_ff : err_ff;
   assign prod_in = ProdBits'($signed({1'b0, mul_a})) * ProdBits'(mul_b);

   // floor(prod / 256)
   assign term     = prod_ff[ProdBits-1:8];
   assign term_ext = {term[TermBits-1], term};
   assign pi_mag   = pi_ff[PiBits-1] ? (~pi_ff + 1'b1) : pi_ff;

   // restoring divider, one quotient bit per step
   assign divisor   = (dac_scale_ff == '0) ? GainBits'(1) : dac_scale_ff;
   assign rem_shift = {rem_ff, dq_ff[PiBits-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor};
   assign quo_bit   = (rem_shift >= {1'b0, divisor});
   assign rem_in    = quo_bit ? rem_diff[GainBits-1:0] : rem_shift[GainBits-1:0];
   assign dq_in     = {dq_ff[PiBits-2:0], quo_bit};

   // rate limit, then clamp to the DAC range
   assign delta_mag = (dq_ff > PiBits'(step_limit_ff)) ? step_limit_ff
                                                       : dq_ff[StepBits-1:0];
   assign delta     = neg_ff ? (~{1'b0, delta_mag} + 1'b1) : {1'b0, delta_mag};
   assign raw_sum   = {{(SumBits-DAC_BITS){1'b0}}, last_output_ff}
                    + {{(SumBits-StepBits-1){delta[StepBits]}}, delta};
   always_comb begin
      if (raw_sum[SumBits-1]) begin
         raw_in = '0;
      end else if (raw_sum > SumBits'({DAC_BITS{1'b1}})) begin
         raw_in = {DAC_BITS{1'b1}};
      end else begin
         raw_in = raw_sum[DAC_BITS-1:0];
      end
   end

   // Q8 blend; a convex mix of two in-range codes stays in range
   assign alpha     = (smooth_alpha_ff > pvtl_pkg::ALPHA_ONE) ? pvtl_pkg::ALPHA_ONE
                                                              : smooth_alpha_ff;
   assign alpha_inv = pvtl_pkg::ALPHA_ONE - alpha;
   assign blend_sum = BlendBits'(alpha) * BlendBits'(raw_ff)
                    + BlendBits'(alpha_inv) * BlendBits'(last_output_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff    <= pvtl_pkg::PROP_GAIN_RESET;
         integ_gain_ff   <= pvtl_pkg::INTEG_GAIN_RESET;
         dac_scale_ff    <= pvtl_pkg::DAC_SCALE_RESET;
         step_limit_ff   <= pvtl_pkg::STEP_LIMIT_RESET;
         smooth_alpha_ff <= pvtl_pkg::SMOOTH_ALPHA_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            pvtl_pkg::CSR_PROP_GAIN:    prop_gain_ff    <= csr_wdata;
            pvtl_pkg::CSR_INTEG_GAIN:   integ_gain_ff   <= csr_wdata;
            pvtl_pkg::CSR_DAC_SCALE:    dac_scale_ff    <= csr_wdata;
            pvtl_pkg::CSR_STEP_LIMIT:   step_limit_ff   <= csr_wdata[StepBits-1:0];
            pvtl_pkg::CSR_SMOOTH_ALPHA: smooth_alpha_ff <= csr_wdata[AlphaBits-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esum_ff        <= '0;
         last_output_ff <= {1'b1, {(DAC_BITS-1){1'b0}}};
      end else begin
         if (cmd.load) begin
            esum_ff <= esum_in;
         end
         if (cmd.op == pvtl_pkg::OP_BLEND) begin
            last_output_ff <= blend_sum[BlendBits-2:8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff <= req_freq_error;
      end
      unique case (cmd.op)
         pvtl_pkg::OP_MUL_P,
         pvtl_pkg::OP_MUL_I: begin
            prod_ff <= prod_in;
         end
         pvtl_pkg::OP_ACC_P: begin
            pi_ff <= term_ext;
         end
         pvtl_pkg::OP_ACC_I: begin
            pi_ff <= pi_ff + term_ext;
         end
         pvtl_pkg::OP_DIV_INIT: begin
            neg_ff <= pi_ff[PiBits-1];
            dq_ff  <= pi_mag;
            rem_ff <= '0;
         end
         pvtl_pkg::OP_DIV_STEP: begin
            dq_ff  <= dq_in;
            rem_ff <= rem_in;
         end
         pvtl_pkg::OP_LIMIT: begin
            raw_ff <= raw_in;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ sv/pi_vco_tuning_loop.sv @@
// ----------------------------------------------------------------------------
// pi_vco_tuning_loop
// PI controller with rate limit and low-pass smoothing for a VCO tuning DAC.
// ----------------------------------------------------------------------------
//  port group  | direction | contents
//  req_*       | in        | freq_error, signed ERROR_BITS, valid/ready
//  rsp_*       | out       | dac_code, DAC_BITS unsigned, valid/ready
//  csr_*       | in        | wen/index/wdata, write only, takes effect next cycle
//
//  One request is processed at a time; after the request transfer the update
//  steps through the P and I products, the divider, the rate limit and the
//  blend, and the result is valid once the blend writes the output. The
//  restoring divider makes one quotient bit per clock over ERROR_BITS+10 bits.
//  A new request is taken while the previous result waits; the update stalls
//  just before writing the output until that result has been transferred.
//  Reset: integral zero, output at midscale, registers at their defaults.
// ----------------------------------------------------------------------------
module pi_vco_tuning_loop #(
   parameter int DAC_BITS   = pvtl_pkg::DAC_BITS_DEFAULT,
   parameter int ERROR_BITS = pvtl_pkg::ERROR_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ERROR_BITS-1:0]        req_freq_error,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [DAC_BITS-1:0]                 rsp_dac_code,
   input  logic                                csr_wen,
   input  logic [pvtl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pvtl_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   pvtl_pkg::dp_cmd_type cmd;

   pvtl_ctrl #(
      .ERROR_BITS (ERROR_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   pvtl_datapath #(
      .DAC_BITS   (DAC_BITS),
      .ERROR_BITS (ERROR_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .req_freq_error (req_freq_error),
      .rsp_dac_code   (rsp_dac_code)
   );

endmodule
